// ===== hdl/camellia_pkg.sv =====
`default_nettype none
package camellia_pkg;

   localparam int unsigned ROUNDS_LONG = 24;
   localparam int unsigned CSR_IDX_W = 3;

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_W0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_W1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_W2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_W3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_SIZE = 3'd4;

   // key size codes
   localparam logic [1:0] KSZ_128 = 2'd0;
   localparam logic [1:0] KSZ_192 = 2'd1;
   localparam logic [1:0] KSZ_256 = 2'd2;

   // key schedule steps
   localparam logic [2:0] KS_LOAD = 3'd0;
   localparam logic [2:0] KS_F0 = 3'd1;
   localparam logic [2:0] KS_F1 = 3'd2;
   localparam logic [2:0] KS_F2 = 3'd3;
   localparam logic [2:0] KS_F3 = 3'd4;
   localparam logic [2:0] KS_F4 = 3'd5;
   localparam logic [2:0] KS_F5 = 3'd6;

   localparam logic [63:0] SIGMA1 = 64'hA09E667F3BCC908B;
   localparam logic [63:0] SIGMA2 = 64'hB67AE8584CAA73B2;
   localparam logic [63:0] SIGMA3 = 64'hC6EF372FE94F82BE;
   localparam logic [63:0] SIGMA4 = 64'h54FF53A5F1D36F1C;
   localparam logic [63:0] SIGMA5 = 64'h10E527FADE682D1D;
   localparam logic [63:0] SIGMA6 = 64'hB05688C2B3E6C1FD;

   localparam logic [7:0] SBOX1 [256] = '{
      8'h70,8'h82,8'h2C,8'hEC,8'hB3,8'h27,8'hC0,8'hE5,8'hE4,8'h85,8'h57,8'h35,8'hEA,8'h0C,8'hAE,8'h41,
      8'h23,8'hEF,8'h6B,8'h93,8'h45,8'h19,8'hA5,8'h21,8'hED,8'h0E,8'h4F,8'h4E,8'h1D,8'h65,8'h92,8'hBD,
      8'h86,8'hB8,8'hAF,8'h8F,8'h7C,8'hEB,8'h1F,8'hCE,8'h3E,8'h30,8'hDC,8'h5F,8'h5E,8'hC5,8'h0B,8'h1A,
      8'hA6,8'hE1,8'h39,8'hCA,8'hD5,8'h47,8'h5D,8'h3D,8'hD9,8'h01,8'h5A,8'hD6,8'h51,8'h56,8'h6C,8'h4D,
      8'h8B,8'h0D,8'h9A,8'h66,8'hFB,8'hCC,8'hB0,8'h2D,8'h74,8'h12,8'h2B,8'h20,8'hF0,8'hB1,8'h84,8'h99,
      8'hDF,8'h4C,8'hCB,8'hC2,8'h34,8'h7E,8'h76,8'h05,8'h6D,8'hB7,8'hA9,8'h31,8'hD1,8'h17,8'h04,8'hD7,
      8'h14,8'h58,8'h3A,8'h61,8'hDE,8'h1B,8'h11,8'h1C,8'h32,8'h0F,8'h9C,8'h16,8'h53,8'h18,8'hF2,8'h22,
      8'hFE,8'h44,8'hCF,8'hB2,8'hC3,8'hB5,8'h7A,8'h91,8'h24,8'h08,8'hE8,8'hA8,8'h60,8'hFC,8'h69,8'h50,
      8'hAA,8'hD0,8'hA0,8'h7D,8'hA1,8'h89,8'h62,8'h97,8'h54,8'h5B,8'h1E,8'h95,8'hE0,8'hFF,8'h64,8'hD2,
      8'h10,8'hC4,8'h00,8'h48,8'hA3,8'hF7,8'h75,8'hDB,8'h8A,8'h03,8'hE6,8'hDA,8'h09,8'h3F,8'hDD,8'h94,
      8'h87,8'h5C,8'h83,8'h02,8'hCD,8'h4A,8'h90,8'h33,8'h73,8'h67,8'hF6,8'hF3,8'h9D,8'h7F,8'hBF,8'hE2,
      8'h52,8'h9B,8'hD8,8'h26,8'hC8,8'h37,8'hC6,8'h3B,8'h81,8'h96,8'h6F,8'h4B,8'h13,8'hBE,8'h63,8'h2E,
      8'hE9,8'h79,8'hA7,8'h8C,8'h9F,8'h6E,8'hBC,8'h8E,8'h29,8'hF5,8'hF9,8'hB6,8'h2F,8'hFD,8'hB4,8'h59,
      8'h78,8'h98,8'h06,8'h6A,8'hE7,8'h46,8'h71,8'hBA,8'hD4,8'h25,8'hAB,8'h42,8'h88,8'hA2,8'h8D,8'hFA,
      8'h72,8'h07,8'hB9,8'h55,8'hF8,8'hEE,8'hAC,8'h0A,8'h36,8'h49,8'h2A,8'h68,8'h3C,8'h38,8'hF1,8'hA4,
      8'h40,8'h28,8'hD3,8'h7B,8'hBB,8'hC9,8'h43,8'hC1,8'h15,8'hE3,8'hAD,8'hF4,8'h77,8'hC7,8'h80,8'h9E
   };

   function automatic logic [7:0] rotl1_8(input logic [7:0] v);
      return {v[6:0], v[7]};
   endfunction

   function automatic logic [63:0] cam_f(input logic [63:0] x, input logic [63:0] k);
      logic [63:0] t;
      logic [7:0] y [8];
      logic [7:0] z [8];
      t = x ^ k;
      y[0] = SBOX1[t[63:56]];
      y[1] = rotl1_8(SBOX1[t[55:48]]);
      y[2] = {SBOX1[t[47:40]][0], SBOX1[t[47:40]][7:1]};
      y[3] = SBOX1[rotl1_8(t[39:32])];
      y[4] = rotl1_8(SBOX1[t[31:24]]);
      y[5] = {SBOX1[t[23:16]][0], SBOX1[t[23:16]][7:1]};
      y[6] = SBOX1[rotl1_8(t[15:8])];
      y[7] = SBOX1[t[7:0]];
      z[0] = y[0] ^ y[2] ^ y[3] ^ y[5] ^ y[6] ^ y[7];
      z[1] = y[0] ^ y[1] ^ y[3] ^ y[4] ^ y[6] ^ y[7];
      z[2] = y[0] ^ y[1] ^ y[2] ^ y[4] ^ y[5] ^ y[7];
      z[3] = y[1] ^ y[2] ^ y[3] ^ y[4] ^ y[5] ^ y[6];
      z[4] = y[0] ^ y[1] ^ y[5] ^ y[6] ^ y[7];
      z[5] = y[1] ^ y[2] ^ y[4] ^ y[6] ^ y[7];
      z[6] = y[2] ^ y[3] ^ y[4] ^ y[5] ^ y[7];
      z[7] = y[0] ^ y[3] ^ y[4] ^ y[5] ^ y[6];
      return {z[0], z[1], z[2], z[3], z[4], z[5], z[6], z[7]};
   endfunction

   function automatic logic [63:0] cam_fl(input logic [63:0] x, input logic [63:0] k);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] t;
      a = x[63:32];
      b = x[31:0];
      t = a & k[63:32];
      b = b ^ {t[30:0], t[31]};
      a = a ^ (b | k[31:0]);
      return {a, b};
   endfunction

   function automatic logic [63:0] cam_fl_inv(input logic [63:0] x, input logic [63:0] k);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] t;
      a = x[63:32];
      b = x[31:0];
      a = a ^ (b | k[31:0]);
      t = a & k[63:32];
      b = b ^ {t[30:0], t[31]};
      return {a, b};
   endfunction

endpackage
`default_nettype wire

// ===== hdl/camellia_block_cipher_top.sv =====
`default_nettype none
// channel | direction | handshake            | payload
// req     | in        | req_tvalid/req_tready | tdata {block_lo, block_hi}, tuser func
// rsp     | out       | rsp_tvalid/rsp_tready | tdata {result_lo, result_hi}
// csr     | in        | csr_we                | csr_index, csr_wdata
// one request per cycle unless stalled; input whitening stage, 24 round stages, output
// register; 128-bit keys pass the last six round stages unchanged. reset and each key
// or key size write run the key schedule (load, F0 to F5) on the one shared F unit,
// with req_tready low; a low rsp_tready with rsp_tvalid high stalls the whole pipeline.
module camellia_block_cipher_top (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire logic [127:0]   req_tdata,   // block_hi [63:0], block_lo [127:64]
   input  wire logic           req_tuser,   // func
   output logic                rsp_tvalid,
   input  wire logic           rsp_tready,
   output logic [127:0]        rsp_tdata,   // result_hi [63:0], result_lo [127:64]
   input  wire logic           csr_we,
   input  wire logic [camellia_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0]    csr_wdata
);
   import camellia_pkg::*;

   logic [63:0] kw0_ff, kw1_ff, kw2_ff, kw3_ff;
   logic [1:0]  ksz_ff;
   logic        busy_ff, busy_in;
   logic [2:0]  kstep_ff, kstep_in;
   logic [63:0] kp_ff, kp_in, kq_ff, kq_in;
   logic [127:0] ka_ff, ka_in, kb_ff, kb_in;
   logic        csr_hit;
   logic        long_key;
   logic [127:0] kl, kr;
   logic [63:0] f_x, f_k, f_y;

   assign csr_hit = csr_we && (csr_index <= CSR_KEY_SIZE);
   assign long_key = (ksz_ff != KSZ_128);
   assign kl = {kw0_ff, kw1_ff};
   assign kr = !long_key ? 128'd0 :
               (ksz_ff == KSZ_192) ? {kw2_ff, ~kw2_ff} : {kw2_ff, kw3_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         kw0_ff <= '0;
         kw1_ff <= '0;
         kw2_ff <= '0;
         kw3_ff <= '0;
         ksz_ff <= KSZ_128;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_W0: kw0_ff <= csr_wdata;
            CSR_KEY_W1: kw1_ff <= csr_wdata;
            CSR_KEY_W2: kw2_ff <= csr_wdata;
            CSR_KEY_W3: kw3_ff <= csr_wdata;
            CSR_KEY_SIZE: ksz_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // key schedule: one F evaluation per step after the load step
   always_comb begin
      case (kstep_ff)
         KS_F0: begin f_x = kp_ff; f_k = SIGMA1; end
         KS_F1: begin f_x = kq_ff; f_k = SIGMA2; end
         KS_F2: begin f_x = kp_ff ^ kl[127:64]; f_k = SIGMA3; end
         KS_F3: begin f_x = kq_ff; f_k = SIGMA4; end
         KS_F4: begin f_x = ka_ff[127:64] ^ kr[127:64]; f_k = SIGMA5; end
         KS_F5: begin f_x = kq_ff; f_k = SIGMA6; end
         default: begin f_x = kp_ff; f_k = SIGMA1; end
      endcase
   end
   assign f_y = cam_f(f_x, f_k);

   always_comb begin
      busy_in = busy_ff;
      kstep_in = kstep_ff;
      kp_in = kp_ff;
      kq_in = kq_ff;
      ka_in = ka_ff;
      kb_in = kb_ff;
      if (busy_ff) begin
         kstep_in = kstep_ff + 3'd1;
         case (kstep_ff)
            KS_LOAD: begin
               kp_in = kl[127:64] ^ kr[127:64];
               kq_in = kl[63:0] ^ kr[63:0];
            end
            KS_F0: kq_in = kq_ff ^ f_y;
            KS_F1: kp_in = kp_ff ^ f_y;
            KS_F2: begin
               kp_in = kp_ff ^ kl[127:64];
               kq_in = kq_ff ^ kl[63:0] ^ f_y;
            end
            KS_F3: begin
               kp_in = kp_ff ^ f_y;
               ka_in = {kp_ff ^ f_y, kq_ff};
            end
            KS_F4: begin
               kp_in = f_x;
               kq_in = ka_ff[63:0] ^ kr[63:0] ^ f_y;
            end
            KS_F5: begin
               kp_in = kp_ff ^ f_y;
               kb_in = {kp_ff ^ f_y, kq_ff};
               busy_in = 1'b0;
            end
            default: busy_in = 1'b0;
         endcase
      end
      if (csr_hit) begin
         busy_in = 1'b1;
         kstep_in = KS_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         kstep_ff <= KS_LOAD;
      end else begin
         busy_ff <= busy_in;
         kstep_ff <= kstep_in;
      end
      kp_ff <= kp_in;
      kq_ff <= kq_in;
      ka_ff <= ka_in;
      kb_ff <= kb_in;
   end

   // subkeys, fixed rotations of kl, kr, ka, kb; unused ones are zero for 128-bit keys
   logic [63:0] wk [4];
   logic [63:0] rk [ROUNDS_LONG];
   logic [63:0] fk [6];
   logic [127:0] kl15, kl45, kl60, kl77, kl94, kl111;
   logic [127:0] ka15, ka30, ka45, ka60, ka77, ka94, ka111;
   logic [127:0] kr15, kr30, kr60, kr94, kb30, kb60, kb111;

   assign kl15 = {kl[112:0], kl[127:113]};
   assign kl45 = {kl[82:0], kl[127:83]};
   assign kl60 = {kl[67:0], kl[127:68]};
   assign kl77 = {kl[50:0], kl[127:51]};
   assign kl94 = {kl[33:0], kl[127:34]};
   assign kl111 = {kl[16:0], kl[127:17]};
   assign ka15 = {ka_ff[112:0], ka_ff[127:113]};
   assign ka30 = {ka_ff[97:0], ka_ff[127:98]};
   assign ka45 = {ka_ff[82:0], ka_ff[127:83]};
   assign ka60 = {ka_ff[67:0], ka_ff[127:68]};
   assign ka77 = {ka_ff[50:0], ka_ff[127:51]};
   assign ka94 = {ka_ff[33:0], ka_ff[127:34]};
   assign ka111 = {ka_ff[16:0], ka_ff[127:17]};
   assign kr15 = {kr[112:0], kr[127:113]};
   assign kr30 = {kr[97:0], kr[127:98]};
   assign kr60 = {kr[67:0], kr[127:68]};
   assign kr94 = {kr[33:0], kr[127:34]};
   assign kb30 = {kb_ff[97:0], kb_ff[127:98]};
   assign kb60 = {kb_ff[67:0], kb_ff[127:68]};
   assign kb111 = {kb_ff[16:0], kb_ff[127:17]};

   always_comb begin
      {wk[0], wk[1]} = kl;
      if (!long_key) begin
         {rk[0], rk[1]} = ka_ff;
         {rk[2], rk[3]} = kl15;
         {rk[4], rk[5]} = ka15;
         {fk[0], fk[1]} = ka30;
         {rk[6], rk[7]} = kl45;
         rk[8] = ka45[127:64];
         rk[9] = kl60[63:0];
         {rk[10], rk[11]} = ka60;
         {fk[2], fk[3]} = kl77;
         {rk[12], rk[13]} = kl94;
         {rk[14], rk[15]} = ka94;
         {rk[16], rk[17]} = kl111;
         {wk[2], wk[3]} = ka111;
         {rk[18], rk[19]} = '0;
         {rk[20], rk[21]} = '0;
         {rk[22], rk[23]} = '0;
         {fk[4], fk[5]} = '0;
      end else begin
         {rk[0], rk[1]} = kb_ff;
         {rk[2], rk[3]} = kr15;
         {rk[4], rk[5]} = ka15;
         {fk[0], fk[1]} = kr30;
         {rk[6], rk[7]} = kb30;
         {rk[8], rk[9]} = kl45;
         {rk[10], rk[11]} = ka45;
         {fk[2], fk[3]} = kl60;
         {rk[12], rk[13]} = kr60;
         {rk[14], rk[15]} = kb60;
         {rk[16], rk[17]} = kl77;
         {fk[4], fk[5]} = ka77;
         {rk[18], rk[19]} = kr94;
         {rk[20], rk[21]} = ka94;
         {rk[22], rk[23]} = kl111;
         {wk[2], wk[3]} = kb111;
      end
   end

   // data pipeline
   logic        adv;
   logic        v_ff [ROUNDS_LONG+1];
   logic        dec_ff [ROUNDS_LONG+1];
   logic [63:0] p_ff [ROUNDS_LONG+1];
   logic [63:0] q_ff [ROUNDS_LONG+1];
   logic        rsp_valid_ff;
   logic [127:0] rsp_data_ff;

   assign adv = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv && !busy_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= req_tvalid && !busy_ff;
      end
      if (adv) begin
         dec_ff[0] <= req_tuser;
         p_ff[0] <= req_tdata[63:0] ^ (req_tuser ? wk[2] : wk[0]);
         q_ff[0] <= req_tdata[127:64] ^ (req_tuser ? wk[3] : wk[1]);
      end
   end

   for (genvar j = 0; j < ROUNDS_LONG; j++) begin : g_round
      localparam int unsigned LAYER = (j + 1) / 6;
      localparam bit HAS_FL = ((j + 1) % 6 == 0) && (j + 1 < ROUNDS_LONG);
      localparam bit FL_SHORT = HAS_FL && (j + 1 < 18);
      localparam int unsigned ENC_A = HAS_FL ? 2 * (LAYER - 1) : 0;
      localparam int unsigned DEC_B_S = FL_SHORT ? 2 * (2 - LAYER) : 0;
      localparam int unsigned DEC_B_L = HAS_FL ? 2 * (3 - LAYER) : 0;
      localparam int unsigned DEC_S = (j < 18) ? 17 - j : 0;

      logic [63:0] key;
      logic [63:0] fo;
      logic [63:0] p_r, q_r, p_n, q_n;
      logic        active;

      always_comb begin
         active = long_key || (j < 18);
         if (!dec_ff[j]) begin
            key = rk[j];
         end else if (long_key) begin
            key = rk[ROUNDS_LONG-1-j];
         end else begin
            key = rk[DEC_S];
         end
         fo = cam_f((j % 2 == 0) ? p_ff[j] : q_ff[j], key);
         p_r = (j % 2 == 0) ? p_ff[j] : p_ff[j] ^ fo;
         q_r = (j % 2 == 0) ? q_ff[j] ^ fo : q_ff[j];
         p_n = p_r;
         q_n = q_r;
         if (HAS_FL && (long_key || FL_SHORT)) begin
            if (!dec_ff[j]) begin
               p_n = cam_fl(p_r, fk[ENC_A]);
               q_n = cam_fl_inv(q_r, fk[ENC_A+1]);
            end else if (long_key) begin
               p_n = cam_fl(p_r, fk[DEC_B_L+1]);
               q_n = cam_fl_inv(q_r, fk[DEC_B_L]);
            end else begin
               p_n = cam_fl(p_r, fk[DEC_B_S+1]);
               q_n = cam_fl_inv(q_r, fk[DEC_B_S]);
            end
         end
         if (!active) begin
            p_n = p_ff[j];
            q_n = q_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j+1] <= 1'b0;
         end else if (adv) begin
            v_ff[j+1] <= v_ff[j];
         end
         if (adv) begin
            dec_ff[j+1] <= dec_ff[j];
            p_ff[j+1] <= p_n;
            q_ff[j+1] <= q_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v_ff[ROUNDS_LONG];
      end
      if (adv) begin
         rsp_data_ff[63:0] <= q_ff[ROUNDS_LONG] ^ (dec_ff[ROUNDS_LONG] ? wk[0] : wk[2]);
         rsp_data_ff[127:64] <= p_ff[ROUNDS_LONG] ^ (dec_ff[ROUNDS_LONG] ? wk[1] : wk[3]);
      end
   end

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none
module tb;
   import camellia_pkg::*;

   typedef struct packed {
      logic       func;
      logic [63:0] hi;
      logic [63:0] lo;
   } cipher_req_type;

   typedef struct packed {
      logic [63:0] hi;
      logic [63:0] lo;
   } cipher_blk_type;

   typedef struct {
      cipher_req_type req;
      logic        has_exp;
      cipher_blk_type exp;
   } vector_row_type;

   localparam int unsigned WATCHDOG_LIMIT = 20000;
   localparam int unsigned DRAIN_CYCLES = 60;
   // index past the register list
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_UNUSED = 3'd6;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [127:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   // predictor copy of the key registers and the expanded subkeys
   logic [63:0] key_reg [4];
   logic [1:0] key_size_reg;
   logic [63:0] subkeys [34];

   cipher_blk_type expected_blocks [$];
   int unsigned failures = 0;
   int unsigned blocks_sent = 0;
   int unsigned blocks_checked = 0;
   int unsigned idle_cycles = 0;
   logic rsp_idle_en = 1'b1;
   logic rsp_hold = 1'b0;
   logic req_idle_en = 1'b1;

   camellia_block_cipher_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic logic [7:0] rol8(input logic [7:0] v, input int n);
      return (v << n) | (v >> (8 - n));
   endfunction

   function automatic logic [63:0] round_f(input logic [63:0] x, input logic [63:0] k);
      logic [63:0] t;
      logic [7:0] b [8];
      logic [7:0] y [8];
      t = x ^ k;
      for (int i = 0; i < 8; i++) b[i] = t[63-8*i -: 8];
      y[0] = SBOX1[b[0]];
      y[1] = rol8(SBOX1[b[1]], 1);
      y[2] = rol8(SBOX1[b[2]], 7);
      y[3] = SBOX1[rol8(b[3], 1)];
      y[4] = rol8(SBOX1[b[4]], 1);
      y[5] = rol8(SBOX1[b[5]], 7);
      y[6] = SBOX1[rol8(b[6], 1)];
      y[7] = SBOX1[b[7]];
      return {y[0]^y[2]^y[3]^y[5]^y[6]^y[7], y[0]^y[1]^y[3]^y[4]^y[6]^y[7],
              y[0]^y[1]^y[2]^y[4]^y[5]^y[7], y[1]^y[2]^y[3]^y[4]^y[5]^y[6],
              y[0]^y[1]^y[5]^y[6]^y[7], y[1]^y[2]^y[4]^y[6]^y[7],
              y[2]^y[3]^y[4]^y[5]^y[7], y[0]^y[3]^y[4]^y[5]^y[6]};
   endfunction

   function automatic logic [63:0] fl_layer(input logic [63:0] x, input logic [63:0] k,
                                            input logic inverse);
      logic [31:0] a, b, t;
      a = x[63:32];
      b = x[31:0];
      if (inverse) a ^= b | k[31:0];
      t = a & k[63:32];
      b ^= {t[30:0], t[31]};
      if (!inverse) a ^= b | k[31:0];
      return {a, b};
   endfunction

   function automatic logic [127:0] rot128(input logic [127:0] v, input int n);
      return (v << n) | (v >> (128 - n));
   endfunction

   task automatic store_pair(input int idx, input logic [127:0] v, input int n);
      logic [127:0] r;
      r = rot128(v, n);
      subkeys[idx] = r[127:64];
      subkeys[idx+1] = r[63:0];
   endtask

   task automatic expand_schedule();
      logic [127:0] kl, kr, ka, kb;
      logic [63:0] p, q;
      logic [127:0] r;
      kl = {key_reg[0], key_reg[1]};
      kr = '0;
      if (key_size_reg != KSZ_128)
         kr = {key_reg[2], (key_size_reg == KSZ_192) ? ~key_reg[2] : key_reg[3]};
      p = kl[127:64] ^ kr[127:64];
      q = kl[63:0] ^ kr[63:0];
      q ^= round_f(p, SIGMA1);
      p ^= round_f(q, SIGMA2);
      p ^= kl[127:64];
      q ^= kl[63:0];
      q ^= round_f(p, SIGMA3);
      p ^= round_f(q, SIGMA4);
      ka = {p, q};
      p ^= kr[127:64];
      q ^= kr[63:0];
      q ^= round_f(p, SIGMA5);
      p ^= round_f(q, SIGMA6);
      kb = {p, q};
      for (int i = 0; i < 34; i++) subkeys[i] = '0;
      store_pair(0, kl, 0);
      if (key_size_reg == KSZ_128) begin
         store_pair(4, ka, 0);
         store_pair(6, kl, 15);
         store_pair(8, ka, 15);
         store_pair(28, ka, 30);
         store_pair(10, kl, 45);
         r = rot128(ka, 45);
         subkeys[12] = r[127:64];
         r = rot128(kl, 60);
         subkeys[13] = r[63:0];
         store_pair(14, ka, 60);
         store_pair(30, kl, 77);
         store_pair(16, kl, 94);
         store_pair(18, ka, 94);
         store_pair(20, kl, 111);
         store_pair(2, ka, 111);
      end else begin
         store_pair(4, kb, 0);
         store_pair(6, kr, 15);
         store_pair(8, ka, 15);
         store_pair(28, kr, 30);
         store_pair(10, kb, 30);
         store_pair(12, kl, 45);
         store_pair(14, ka, 45);
         store_pair(30, kl, 60);
         store_pair(16, kr, 60);
         store_pair(18, kb, 60);
         store_pair(20, kl, 77);
         store_pair(32, ka, 77);
         store_pair(22, kr, 94);
         store_pair(24, ka, 94);
         store_pair(26, kl, 111);
         store_pair(2, kb, 111);
      end
   endtask

   function automatic cipher_blk_type predict_block(input cipher_req_type rq);
      int rounds, i0, i1, layer, fa, fb;
      logic [63:0] p, q;
      logic dec;
      cipher_blk_type res;
      dec = rq.func;
      rounds = (key_size_reg == KSZ_128) ? 18 : 24;
      p = rq.hi ^ subkeys[dec ? 2 : 0];
      q = rq.lo ^ subkeys[dec ? 3 : 1];
      for (int r = 0; r < rounds; r += 2) begin
         i0 = dec ? rounds - 1 - r : r;
         i1 = dec ? rounds - 2 - r : r + 1;
         q ^= round_f(p, subkeys[4 + i0]);
         p ^= round_f(q, subkeys[4 + i1]);
         if ((r + 2) % 6 == 0 && r + 2 < rounds) begin
            layer = (r + 2) / 6;
            if (!dec) begin
               fa = 2 * (layer - 1);
               fb = fa + 1;
            end else begin
               fb = 2 * (rounds / 6 - 1 - layer);
               fa = fb + 1;
            end
            p = fl_layer(p, subkeys[28 + fa], 1'b0);
            q = fl_layer(q, subkeys[28 + fb], 1'b1);
         end
      end
      res.hi = q ^ subkeys[dec ? 0 : 2];
      res.lo = p ^ subkeys[dec ? 1 : 3];
      return res;
   endfunction

   function automatic logic [63:0] rand64();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_KEY_W0: key_reg[0] = val;
         CSR_KEY_W1: key_reg[1] = val;
         CSR_KEY_W2: key_reg[2] = val;
         CSR_KEY_W3: key_reg[3] = val;
         CSR_KEY_SIZE: key_size_reg = val[1:0];
         default: return;
      endcase
      expand_schedule();
   endtask

   task automatic wait_drained();
      wait (expected_blocks.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_block(input cipher_req_type rq, input logic has_exp,
                             input cipher_blk_type exp);
      while (req_idle_en && $urandom_range(0, 99) < 24) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {rq.lo, rq.hi};
      req_tuser <= rq.func;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_blocks.push_back(has_exp ? exp : predict_block(rq));
      blocks_sent++;
   endtask

   // receiver side: random stalls and a long hold-off on request
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (rsp_hold) rsp_tready <= 1'b0;
      else rsp_tready <= !(rsp_idle_en && $urandom_range(0, 99) < 24);
   end

   always @(posedge clock) begin
      cipher_blk_type got, exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[63:0], rsp_tdata[127:64]};
         if (expected_blocks.size() == 0) begin
            $error("unexpected response %h", rsp_tdata);
            failures++;
         end else begin
            exp = expected_blocks.pop_front();
            blocks_checked++;
            if (got.hi !== exp.hi) begin
               $error("result_hi expected %h actual %h", exp.hi, got.hi);
               failures++;
            end
            if (got.lo !== exp.lo) begin
               $error("result_lo expected %h actual %h", exp.lo, got.lo);
               failures++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      vector_row_type vectors [$];
      vector_row_type row;
      cipher_req_type rq;
      cipher_blk_type none;
      none = '0;
      for (int i = 0; i < 4; i++) key_reg[i] = '0;
      key_size_reg = KSZ_128;
      expand_schedule();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero key after reset, extremes, both directions
      vectors.push_back('{'{1'b0, 64'h0, 64'h0}, 1'b0, none});
      vectors.push_back('{'{1'b1, 64'h0, 64'h0}, 1'b0, none});
      vectors.push_back('{'{1'b0, '1, '1}, 1'b0, none});
      vectors.push_back('{'{1'b1, '1, '1}, 1'b0, none});
      vectors.push_back('{'{1'b0, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210}, 1'b0, none});
      vectors.push_back('{'{1'b0, 64'h8000000000000000, 64'h1}, 1'b0, none});
      foreach (vectors[i]) send_block(vectors[i].req, vectors[i].has_exp, vectors[i].exp);
      req_tvalid <= 1'b0;
      wait_drained();

      // published 128-bit test vector
      write_reg(CSR_KEY_W0, 64'h0123456789ABCDEF);
      write_reg(CSR_KEY_W1, 64'hFEDCBA9876543210);
      row = '{'{1'b0, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210}, 1'b1,
              '{64'h6767313854966973, 64'h0857065648EABE43}};
      send_block(row.req, row.has_exp, row.exp);
      row = '{'{1'b1, 64'h6767313854966973, 64'h0857065648EABE43}, 1'b1,
              '{64'h0123456789ABCDEF, 64'hFEDCBA9876543210}};
      send_block(row.req, row.has_exp, row.exp);
      req_tvalid <= 1'b0;
      wait_drained();

      // 192-bit and 256-bit keys, with key word 3 ignored in the 192-bit case
      write_reg(CSR_KEY_W2, 64'h0011223344556677);
      write_reg(CSR_KEY_W3, 64'h8899AABBCCDDEEFF);
      write_reg(CSR_KEY_SIZE, {62'b0, KSZ_192});
      row = '{'{1'b0, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210}, 1'b1,
              '{64'hB4993401B3E996F8, 64'h4EE5CEE7D79B09B9}};
      send_block(row.req, row.has_exp, row.exp);
      req_tvalid <= 1'b0;
      wait_drained();
      write_reg(CSR_KEY_SIZE, {62'b0, KSZ_256});
      row = '{'{1'b0, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210}, 1'b0, none};
      send_block(row.req, row.has_exp, row.exp);
      req_tvalid <= 1'b0;
      wait_drained();
      // key size three behaves as 256-bit; out-of-range index is ignored
      write_reg(CSR_KEY_SIZE, 64'd3);
      write_reg(CSR_IDX_UNUSED, '1);
      for (int i = 0; i < 4; i++) begin
         rq = '{i[0], rand64(), rand64()};
         send_block(rq, 1'b0, none);
      end
      req_tvalid <= 1'b0;
      wait_drained();

      // random phases over key sizes, with a long receiver hold-off in the second
      for (int ph = 0; ph < 10; ph++) begin
         write_reg(CSR_KEY_W0, rand64());
         write_reg(CSR_KEY_W1, rand64());
         write_reg(CSR_KEY_W2, rand64());
         write_reg(CSR_KEY_W3, rand64());
         write_reg(CSR_KEY_SIZE, 64'(ph % 4));
         req_idle_en = (ph != 3);
         rsp_idle_en = (ph != 3);
         if (ph == 1) fork
            begin
               rsp_hold = 1'b1;
               repeat (200) @(posedge clock);
               rsp_hold = 1'b0;
            end
         join_none
         for (int n = 0; n < 48; n++) begin
            rq = '{1'($urandom_range(0, 1)), rand64(), rand64()};
            send_block(rq, 1'b0, none);
         end
         req_tvalid <= 1'b0;
         wait_drained();
      end
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
      $display("sent %0d blocks, checked %0d, over 128/192/256-bit keys both directions",
               blocks_sent, blocks_checked);
      if (failures == 0 && expected_blocks.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
